// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

// ===== rtl/asu_pkg.sv =====
// Shared types and codes for the array stack with reverse unit.
// No dependencies; used by the top level and its checker.
`default_nettype none

package asu_pkg;

    localparam int WORD_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    // Operation codes carried on the kind port.
    localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REVERSE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_RD_LO,
        S_RD_HI,
        S_WR_LO,
        S_WR_HI
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/asu_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module asu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the entry being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/array_stack_with_reverse_unit.sv =====
// LIFO stack of signed 32-bit words with push, pop and whole-stack reverse. A word is taken
// when start is high and busy is low; each word yields one result, shown for exactly one cycle
// with done high, and the receiver cannot stall it. Push, a refused operation, the unused kind
// code and a reverse of a single entry give their result in the cycle after acceptance and keep
// busy low, so one such word can be taken every cycle. A pop holds busy in S_POP while the top
// word is read back, then gives its result. A reverse of n entries (n at least two) holds busy
// while it swaps pairs, and its result comes in the same cycle in which busy falls: the entries
// live in one RAM with one read port and one write port, and each swap of two entries costs two
// reads and two writes. The RAM is not cleared; only entries below the occupancy are ever used.
// Depends on asu_pkg and asu_ram.
`default_nettype none

module array_stack_with_reverse_unit #(
    parameter int DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [asu_pkg::KIND_W-1:0]    kind,
    input  wire logic signed [asu_pkg::WORD_W-1:0] push_value,
    output logic                               done,
    output logic signed [asu_pkg::WORD_W-1:0]  pop_value,
    output logic [asu_pkg::STATUS_W-1:0]       status,
    output logic [asu_pkg::OCC_W-1:0]          occupancy
);

    // Address width of the store and width of the entry count (which must hold DEPTH itself).
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    asu_pkg::state_t state_reg;
    asu_pkg::state_t state_next;

    logic [CW-1:0] count_reg;
    logic [AW-1:0] lo_reg;
    logic [AW-1:0] hi_reg;
    logic [asu_pkg::WORD_W-1:0] lo_word_reg;
    logic          done_reg;
    logic signed [asu_pkg::WORD_W-1:0] pop_value_reg;
    logic [asu_pkg::STATUS_W-1:0] status_reg;

    // RAM port controls.
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [asu_pkg::WORD_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [asu_pkg::WORD_W-1:0] ram_rdata;

    logic          accept;
    logic          full;
    logic          empty;
    logic          more_pairs;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] push_addr;
    logic [AW:0]   span;

    assign busy     = (state_reg != asu_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign top_addr  = AW'(count_reg - CW'(1));
    assign push_addr = AW'(count_reg);

    // After the current swap, another is due while the pointers stay more than two apart.
    assign span       = {1'b0, hi_reg} - {1'b0, lo_reg};
    assign more_pairs = (span > (AW + 1)'(2));

    asu_ram #(
        .WIDTH (asu_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next-state logic. A reverse walks a low and a high pointer toward each other; each pair
    // goes through read low, read high, write low, write high.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            asu_pkg::S_IDLE:
            begin
                if (accept && (kind == asu_pkg::KIND_POP) && !empty)
                begin
                    state_next = asu_pkg::S_POP;
                end
                else if (accept && (kind == asu_pkg::KIND_REVERSE) && (count_reg > CW'(1)))
                begin
                    state_next = asu_pkg::S_RD_LO;
                end
            end
            asu_pkg::S_POP:   state_next = asu_pkg::S_IDLE;
            asu_pkg::S_RD_LO: state_next = asu_pkg::S_RD_HI;
            asu_pkg::S_RD_HI: state_next = asu_pkg::S_WR_LO;
            asu_pkg::S_WR_LO: state_next = asu_pkg::S_WR_HI;
            asu_pkg::S_WR_HI: state_next = more_pairs ? asu_pkg::S_RD_LO : asu_pkg::S_IDLE;
            default:          state_next = asu_pkg::S_IDLE;
        endcase
    end

    // RAM port decode per state. The read data of a read issued in one state is seen in the next.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        case (state_reg)
            asu_pkg::S_IDLE:
            begin
                if (accept && (kind == asu_pkg::KIND_PUSH) && !full)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = push_addr;
                    ram_wdata = push_value;
                end
                ram_raddr = top_addr;
            end
            asu_pkg::S_RD_LO: ram_raddr = lo_reg;
            asu_pkg::S_RD_HI: ram_raddr = hi_reg;
            asu_pkg::S_WR_LO:
            begin
                // The high word arrives now and lands at the low slot.
                ram_we    = 1'b1;
                ram_waddr = lo_reg;
                ram_wdata = ram_rdata;
            end
            asu_pkg::S_WR_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = lo_word_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers: state, entry count, swap pointers and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asu_pkg::S_IDLE;
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            case (state_reg)
                asu_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        case (kind)
                            asu_pkg::KIND_PUSH:
                            begin
                                done_reg <= 1'b1;
                                if (!full)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            asu_pkg::KIND_POP:
                            begin
                                // A good pop reports once the read data is back.
                                if (empty)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    count_reg <= count_reg - CW'(1);
                                end
                            end
                            asu_pkg::KIND_REVERSE:
                            begin
                                if (count_reg > CW'(1))
                                begin
                                    lo_reg <= '0;
                                    hi_reg <= top_addr;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                asu_pkg::S_POP:
                begin
                    done_reg <= 1'b1;
                end
                asu_pkg::S_WR_HI:
                begin
                    lo_reg <= lo_reg + AW'(1);
                    hi_reg <= hi_reg - AW'(1);
                    if (!more_pairs)
                    begin
                        done_reg <= 1'b1;
                    end
                end
                default:
                begin
                    done_reg <= 1'b0;
                end
            endcase
        end
    end

    // Result payload and the saved low word of the pair being swapped.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_value_reg <= '0;
            status_reg    <= asu_pkg::ST_OK;
            if ((kind == asu_pkg::KIND_PUSH) && full)
            begin
                status_reg <= asu_pkg::ST_OVERFLOW;
            end
            else if (((kind == asu_pkg::KIND_POP) || (kind == asu_pkg::KIND_REVERSE)) && empty)
            begin
                status_reg <= asu_pkg::ST_EMPTY;
            end
        end
        if (state_reg == asu_pkg::S_POP)
        begin
            pop_value_reg <= ram_rdata;
        end
        if (state_reg == asu_pkg::S_RD_HI)
        begin
            lo_word_reg <= ram_rdata;
        end
    end

    // The count is already final when the strobe rises and cannot change before it falls.
    assign done      = done_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign occupancy = asu_pkg::OCC_W'(count_reg);

endmodule

`default_nettype wire

// ===== rtl/asu_checker.sv =====
// Port-level checks for the array stack with reverse unit, bound to the top level.
// Depends on asu_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module asu_checker #(
    parameter int DEPTH = 64
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              done,
    input wire logic [asu_pkg::WORD_W-1:0]        pop_value,
    input wire logic [asu_pkg::STATUS_W-1:0]      status,
    input wire logic [asu_pkg::OCC_W-1:0]         occupancy
);

    // A result only follows a word taken in the previous cycle or work that was in progress.
    `ASSERT_CLK(a_done_has_cause, done |-> ($past(start) || $past(busy)), "result without a word")

    // An overflow is only reported on a full stack.
    `ASSERT_CLK(a_overflow_full,
        (done && (status == asu_pkg::ST_OVERFLOW)) |-> (occupancy == asu_pkg::OCC_W'(DEPTH)),
        "overflow reported while not full")

    // An empty status means no entries and no popped word.
    `ASSERT_CLK(a_empty_clean,
        (done && (status == asu_pkg::ST_EMPTY)) |-> ((occupancy == '0) && (pop_value == '0)),
        "empty status with entries or data")

    // Occupancy never exceeds the depth when the field can show it.
    `ASSERT_NEVER(a_occ_bound,
        done && (DEPTH < 128) && (occupancy > asu_pkg::OCC_W'(DEPTH)),
        "occupancy above depth")

endmodule

bind array_stack_with_reverse_unit asu_checker #(
    .DEPTH (DEPTH)
) u_asu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .pop_value (pop_value),
    .status    (status),
    .occupancy (occupancy)
);

`default_nettype wire
